@@ hw/rtl/ssat_pkg.sv @@
// Package for the sorted segment append/truncate unit.
// Holds table sizes, field widths and the controller state type.
// No dependencies.
package ssat_pkg;

    // Table depth in segments.
    localparam int MAX_SEGMENTS = 256;

    // Slot index and entry count widths follow from the depth.
    localparam int SEG_IDX_W = $clog2(MAX_SEGMENTS);
    localparam int SEG_CNT_W = SEG_IDX_W + 1;

    // Fixed field widths of the stream payloads.
    localparam int POS_W   = 32;
    localparam int COEF_W  = 32;
    localparam int SLOT_W  = 8;
    localparam int COUNT_W = 9;

    localparam int IN_DATA_W  = POS_W + 4 * COEF_W;
    localparam int OUT_FLD_W  = SLOT_W + 2 * COUNT_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAST,
        ST_SEARCH,
        ST_WRITE
    } seg_state_t;

endpackage

@@ hw/rtl/sorted_segment_append_truncate_unit.sv @@
// Top level of the sorted segment append/truncate unit.
// Position and coefficient tables are synchronous memories; uses ssat_pkg.
//
//  Channel   | Direction | Payload
//  ----------+-----------+------------------------------------------------
//  s_*       | in        | tdata: new_position, coef_const, coef_linear,
//            |           |        coef_square, coef_cube
//  m_*       | out       | tdata: slot_index, entry_count, removed_count
//            |           | tuser: dropped
//
// An empty table is written at once. Otherwise the last stored position is
// read first; a request above it is appended, and a truncating request
// runs a lower-bound binary search over the n stored entries, with one
// position memory read per search step. Reset is asynchronous and empties the
// table; the memories need no clearing. A stalled result waits in the output
// register while the next request is taken and worked on.
module sorted_segment_append_truncate_unit
    import ssat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // new_position, coef_const, coef_linear, coef_square, coef_cube
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // slot_index, entry_count, removed_count, zero padding
    output logic [OUT_DATA_W-1:0] m_tdata,
    // dropped
    output logic                  m_tuser
);

    // Control state.
    seg_state_t             state_reg, state_next;
    logic [SEG_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;

    // Search and request registers.
    logic [SEG_CNT_W-1:0]   lo_reg, lo_next;
    logic [SEG_CNT_W-1:0]   hi_reg, hi_next;
    logic [SEG_CNT_W-1:0]   len_reg, len_next;
    logic [POS_W-1:0]       pos_reg;
    logic [4*COEF_W-1:0]    coef_reg;
    logic [OUT_FLD_W-1:0]   out_data_reg, out_data_next;
    logic                   out_drop_reg, out_drop_next;

    // Memory ports.
    logic [POS_W-1:0]       pos_mem [MAX_SEGMENTS];
    logic [4*COEF_W-1:0]    coef_mem [MAX_SEGMENTS];
    logic                   rd_en;
    logic [SEG_IDX_W-1:0]   rd_addr;
    logic [POS_W-1:0]       rd_data_reg;
    logic                   wr_en;

    // Search step values.
    logic                   in_acc;
    logic                   out_free;
    logic [SEG_CNT_W-1:0]   step_lo, step_hi, step_mid;
    logic [SEG_CNT_W:0]     step_sum;
    logic [SEG_CNT_W-1:0]   mid_reg, mid_next;
    logic                   full_drop;
    logic [SEG_CNT_W-1:0]   removed;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign full_drop = (len_reg >= SEG_CNT_W'(MAX_SEGMENTS));
    assign removed   = cnt_reg - len_reg;

    // One binary search step on the word read at mid_reg.
    always_comb
    begin
        step_lo = lo_reg;
        step_hi = hi_reg;
        if (rd_data_reg < pos_reg)
        begin
            step_lo = mid_reg + SEG_CNT_W'(1);
        end
        else
        begin
            step_hi = mid_reg;
        end
        step_sum = {1'b0, step_lo} + {1'b0, step_hi};
        step_mid = step_sum[SEG_CNT_W:1];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (cnt_reg == '0) ? ST_WRITE : ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = (pos_reg <= rd_data_reg) ? ST_SEARCH : ST_WRITE;
            end
            ST_SEARCH:
            begin
                if (step_lo >= step_hi)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory controls and datapath next values.
    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[SEG_IDX_W-1:0] - SEG_IDX_W'(1);
        wr_en          = 1'b0;
        cnt_next       = cnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        len_next       = len_reg;
        out_data_next  = out_data_reg;
        out_drop_next  = out_drop_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Read the last stored position, or append to an empty table.
                len_next = '0;
                if (in_acc && (cnt_reg != '0))
                begin
                    rd_en = 1'b1;
                end
            end
            ST_LAST:
            begin
                // Start the lower-bound search over [0, count).
                lo_next  = '0;
                hi_next  = cnt_reg;
                mid_next = cnt_reg >> 1;
                len_next = cnt_reg;
                if (pos_reg <= rd_data_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = mid_next[SEG_IDX_W-1:0];
                end
            end
            ST_SEARCH:
            begin
                lo_next  = step_lo;
                hi_next  = step_hi;
                mid_next = step_mid;
                len_next = step_lo;
                if (step_lo < step_hi)
                begin
                    rd_en   = 1'b1;
                    rd_addr = step_mid[SEG_IDX_W-1:0];
                end
            end
            ST_WRITE:
            begin
                // Store the segment, unless the table is full, and post the result.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (full_drop)
                    begin
                        cnt_next      = SEG_CNT_W'(MAX_SEGMENTS);
                        out_drop_next = 1'b1;
                        out_data_next = {COUNT_W'(0),
                                         COUNT_W'(SEG_CNT_W'(MAX_SEGMENTS)),
                                         SLOT_W'(0)};
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        cnt_next      = len_reg + SEG_CNT_W'(1);
                        out_drop_next = 1'b0;
                        out_data_next = {COUNT_W'(removed),
                                         COUNT_W'(len_reg + SEG_CNT_W'(1)),
                                         SLOT_W'(len_reg[SEG_IDX_W-1:0])};
                    end
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and search registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pos_reg  <= s_tdata[POS_W-1:0];
            coef_reg <= s_tdata[IN_DATA_W-1:POS_W];
        end
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        len_reg      <= len_next;
        out_data_reg <= out_data_next;
        out_drop_reg <= out_drop_next;
    end

    // Position memory: one read port, one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= pos_mem[rd_addr];
        end
        if (wr_en)
        begin
            pos_mem[len_reg[SEG_IDX_W-1:0]] <= pos_reg;
        end
    end

    // Coefficient memory: one row of four words per slot.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coef_mem[len_reg[SEG_IDX_W-1:0]] <= coef_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_FLD_W)'(0), out_data_reg};
    assign m_tuser  = out_drop_reg;

endmodule
